// File: hw/rtl/calendar_date_difference_top_defines.svh
// Assertion macros shared by the calendar date difference RTL.
`ifndef CALENDAR_DATE_DIFFERENCE_TOP_DEFINES_SVH
`define CALENDAR_DATE_DIFFERENCE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define CDD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off during reset.
`define CDD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cdd_pkg.sv
// Package with constants, codes and calendar tables of the date difference block.
package cdd_pkg;

    // Field widths of the date and result items.
    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int DOY_W         = 9;
    localparam int COUNT_W       = 21;
    localparam int M_TDATA_W     = ((COUNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W     = 2;
    localparam int YEAR_BITS_DEF = 12;

    // Pipeline depth, from input register to output register.
    localparam int PIPE_STAGES = 6;

    // Calendar constants.
    localparam int DAYS_PER_YEAR   = 365;
    localparam int CENTURY         = 100;
    localparam int LOW_YEAR_RESET  = 1001;
    localparam int HIGH_YEAR_RESET = 2018;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_YEAR  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_YEAR = 1'b1;

    // Days in the months before the given month of a common year.
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Length of the given month in a common year.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/calendar_date_difference_top.sv
// Top level of the Gregorian date difference block: a six-stage pipeline.
//
// Usage: each request on the s_ channel carries two dates (day, month, year).
// The m_ channel returns one result per request: the absolute number of days
// between the dates in m_tdata, and one validity flag per date in m_tuser.
// The count is zero when either date fails its check (month 1 to 12, day within
// the month with leap Februaries, year inside the configured window).
// A new request is taken every cycle unless a stall fills the pipeline; the
// stages are the input register with window checks, the reciprocal multiply
// for the division by 100, its correction step, the leap and day-of-year
// step, the day-number sum and the output register with the absolute
// difference.
// When the receiver stalls, each stage holds as long as the one after it is
// full, so bubbles are squeezed out and s_tready falls only when all six
// stages hold requests. Nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the year
// window with 1001 to 2018. The user writes the window through cfg_wr_en,
// cfg_index and cfg_wdata only while the pipeline is empty; no logic enforces it.
module calendar_date_difference_top #(
    parameter int YEAR_BITS = cdd_pkg::YEAR_BITS_DEF,
    localparam int S_TDATA_W =
        ((2 * (cdd_pkg::DAY_W + cdd_pkg::MONTH_W + YEAR_BITS) + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [cdd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [YEAR_BITS-1:0]              cfg_wdata,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: day_a, month_a, year_a, day_b, month_b, year_b, zero pad.
    input  logic [S_TDATA_W-1:0]              s_tdata,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: day_count, zero pad.
    output logic [cdd_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser from bit 0: first_valid, second_valid.
    output logic [cdd_pkg::M_TUSER_W-1:0]     m_tuser
);

`include "calendar_date_difference_top_defines.svh"

    localparam int DAY_W     = cdd_pkg::DAY_W;
    localparam int MONTH_W   = cdd_pkg::MONTH_W;
    localparam int DOY_W     = cdd_pkg::DOY_W;
    localparam int COUNT_W   = cdd_pkg::COUNT_W;
    localparam int STAGES    = cdd_pkg::PIPE_STAGES;
    localparam int DATE_W    = DAY_W + MONTH_W + YEAR_BITS;
    // Reciprocal of 100 scaled by 2**DIV_SHIFT; the quotient it gives is low by at most one.
    localparam int DIV_SHIFT = YEAR_BITS + 7;
    localparam int RECIP_100 = (1 << DIV_SHIFT) / cdd_pkg::CENTURY;
    localparam int PROD_W    = 2 * YEAR_BITS + 1;
    localparam int REM_W     = 7;
    localparam int DN_W      = YEAR_BITS + 10;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_BITS-1:0] year;
        logic                 base_ok;
    } st1_t;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_BITS-1:0] year;
        logic                 base_ok;
        logic [PROD_W-1:0]    prod;
    } st2_t;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_BITS-1:0] year;
        logic                 base_ok;
        logic [YEAR_BITS-1:0] quo;
        logic [REM_W-1:0]     rem;
    } st3_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [YEAR_BITS-1:0] leaps;
        logic [DOY_W-1:0]     doy;
        logic                 ok;
    } st4_t;

    typedef struct packed {
        logic [DN_W-1:0] dn;
        logic            ok;
    } st5_t;

    // Year window registers.
    logic [YEAR_BITS-1:0] low_year_reg, low_year_next;
    logic [YEAR_BITS-1:0] high_year_reg, high_year_next;

    // Pipeline control.
    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] adv;

    // Stage data, index 0 for the first date and 1 for the second.
    st1_t st1_reg [2];
    st1_t st1_next [2];
    st2_t st2_reg [2];
    st2_t st2_next [2];
    st3_t st3_reg [2];
    st3_t st3_next [2];
    st4_t st4_reg [2];
    st4_t st4_next [2];
    st5_t st5_reg [2];
    st5_t st5_next [2];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               fv_reg, fv_next;
    logic               sv_reg, sv_next;

    // Temporaries of the combinational steps.
    logic [DAY_W-1:0]     day_in [2];
    logic [MONTH_W-1:0]   month_in [2];
    logic [YEAR_BITS-1:0] year_in [2];
    logic [YEAR_BITS-1:0] prev2 [2];
    logic [YEAR_BITS-1:0] prev3 [2];
    logic [YEAR_BITS-1:0] quo_est [2];
    logic [YEAR_BITS-1:0] rem_est [2];
    logic                 rem_over [2];
    logic [YEAR_BITS-1:0] prev4 [2];
    logic                 year_zero [2];
    logic                 leap [2];
    logic [YEAR_BITS-1:0] leaps_nz [2];
    logic [DAY_W-1:0]     mlen [2];
    logic                 late_month [2];
    logic [DN_W-1:0]      dn_diff;

    // Configuration writes.
    always_comb begin
        low_year_next  = low_year_reg;
        high_year_next = high_year_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                cdd_pkg::CFG_LOW_YEAR:  low_year_next  = cfg_wdata;
                cdd_pkg::CFG_HIGH_YEAR: high_year_next = cfg_wdata;
                default:                low_year_next  = low_year_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_year_reg  <= YEAR_BITS'(cdd_pkg::LOW_YEAR_RESET);
            high_year_reg <= YEAR_BITS'(cdd_pkg::HIGH_YEAR_RESET);
        end else begin
            low_year_reg  <= low_year_next;
            high_year_reg <= high_year_next;
        end
    end

    // Stage advance: a stage moves when it is empty or the next one moves.
    always_comb begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[0];

    // Unpack the request into the two dates.
    assign day_in[0]   = s_tdata[DAY_W-1:0];
    assign month_in[0] = s_tdata[DAY_W +: MONTH_W];
    assign year_in[0]  = s_tdata[DAY_W+MONTH_W +: YEAR_BITS];
    assign day_in[1]   = s_tdata[DATE_W +: DAY_W];
    assign month_in[1] = s_tdata[DATE_W+DAY_W +: MONTH_W];
    assign year_in[1]  = s_tdata[DATE_W+DAY_W+MONTH_W +: YEAR_BITS];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            // Stage 1: month range and year window checks.
            st1_next[i].day     = day_in[i];
            st1_next[i].month   = month_in[i];
            st1_next[i].year    = year_in[i];
            st1_next[i].base_ok = (month_in[i] >= cdd_pkg::MONTH_JAN)
                               && (month_in[i] <= cdd_pkg::MONTH_DEC)
                               && (year_in[i] >= low_year_reg)
                               && (year_in[i] <= high_year_reg);

            // Stage 2: multiply the previous year by the reciprocal of 100.
            prev2[i]            = st1_reg[i].year - YEAR_BITS'(1);
            st2_next[i].day     = st1_reg[i].day;
            st2_next[i].month   = st1_reg[i].month;
            st2_next[i].year    = st1_reg[i].year;
            st2_next[i].base_ok = st1_reg[i].base_ok;
            st2_next[i].prod    = PROD_W'(prev2[i]) * PROD_W'(RECIP_100);

            // Stage 3: correct the estimate so the remainder is below 100.
            prev3[i]    = st2_reg[i].year - YEAR_BITS'(1);
            quo_est[i]  = YEAR_BITS'(st2_reg[i].prod >> DIV_SHIFT);
            rem_est[i]  = prev3[i] - YEAR_BITS'(quo_est[i] * YEAR_BITS'(cdd_pkg::CENTURY));
            rem_over[i] = rem_est[i] >= YEAR_BITS'(cdd_pkg::CENTURY);
            st3_next[i].day     = st2_reg[i].day;
            st3_next[i].month   = st2_reg[i].month;
            st3_next[i].year    = st2_reg[i].year;
            st3_next[i].base_ok = st2_reg[i].base_ok;
            st3_next[i].quo     = quo_est[i] + YEAR_BITS'(rem_over[i]);
            st3_next[i].rem     = rem_over[i]
                                ? REM_W'(rem_est[i] - YEAR_BITS'(cdd_pkg::CENTURY))
                                : REM_W'(rem_est[i]);

            // Stage 4: leap flag, leap years before this one, day check, day of year.
            // A year is a century year when the year before it leaves 99; it is a
            // leap century when that quotient is three modulo four.
            prev4[i]     = st3_reg[i].year - YEAR_BITS'(1);
            year_zero[i] = st3_reg[i].year == '0;
            leap[i]      = year_zero[i]
                        || ((st3_reg[i].year[1:0] == 2'b00)
                            && ((st3_reg[i].rem != REM_W'(cdd_pkg::CENTURY - 1))
                                || (st3_reg[i].quo[1:0] == 2'b11)));
            leaps_nz[i]  = (prev4[i] >> 2) - st3_reg[i].quo + (st3_reg[i].quo >> 2)
                         + YEAR_BITS'(1);
            mlen[i]      = cdd_pkg::month_length(st3_reg[i].month)
                         + DAY_W'((st3_reg[i].month == cdd_pkg::MONTH_FEB) && leap[i]);
            late_month[i] = (st3_reg[i].month > cdd_pkg::MONTH_FEB)
                         && (st3_reg[i].month <= cdd_pkg::MONTH_DEC);
            st4_next[i].year  = st3_reg[i].year;
            st4_next[i].leaps = year_zero[i] ? '0 : leaps_nz[i];
            st4_next[i].doy   = cdd_pkg::days_before_month(st3_reg[i].month)
                              + DOY_W'(st3_reg[i].day) - DOY_W'(1)
                              + DOY_W'(late_month[i] && leap[i]);
            st4_next[i].ok    = st3_reg[i].base_ok
                             && (st3_reg[i].day != '0)
                             && (st3_reg[i].day <= mlen[i]);

            // Stage 5: day number counted from the first day of year zero.
            st5_next[i].dn = DN_W'(st4_reg[i].year) * DN_W'(cdd_pkg::DAYS_PER_YEAR)
                           + DN_W'(st4_reg[i].leaps) + DN_W'(st4_reg[i].doy);
            st5_next[i].ok = st4_reg[i].ok;
        end

        // Stage 6: absolute difference, zero when either date fails.
        dn_diff    = (st5_reg[0].dn > st5_reg[1].dn) ? (st5_reg[0].dn - st5_reg[1].dn)
                                                     : (st5_reg[1].dn - st5_reg[0].dn);
        fv_next    = st5_reg[0].ok;
        sv_next    = st5_reg[1].ok;
        count_next = (st5_reg[0].ok && st5_reg[1].ok) ? COUNT_W'(dn_diff) : '0;
    end

    // Payload registers load when their stage advances.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            if (adv[0]) begin
                st1_reg[i] <= st1_next[i];
            end
            if (adv[1]) begin
                st2_reg[i] <= st2_next[i];
            end
            if (adv[2]) begin
                st3_reg[i] <= st3_next[i];
            end
            if (adv[3]) begin
                st4_reg[i] <= st4_next[i];
            end
            if (adv[4]) begin
                st5_reg[i] <= st5_next[i];
            end
        end
        if (adv[5]) begin
            count_reg <= count_next;
            fv_reg    <= fv_next;
            sv_reg    <= sv_next;
        end
    end

    // Result channel.
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = cdd_pkg::M_TDATA_W'(count_reg);
    assign m_tuser  = {sv_reg, fv_reg};

    // Back pressure reaches the input only when every stage holds a request.
    `CDD_ASSERT_IMP(a_full_when_blocked, !s_tready, (&valid_reg) && !m_tready,
        "request refused while the pipeline has room")
    // An invalid date never produces a nonzero day count.
    `CDD_ASSERT_IMP(a_zero_count_invalid, m_tvalid && (!m_tuser[0] || !m_tuser[1]),
        m_tdata == '0, "nonzero day count for an invalid date")
    // A stalled output keeps the request behind it in stage five.
    `CDD_ASSERT_NXT(a_stall_keeps_stage5, valid_reg[STAGES-2] && m_tvalid && !m_tready,
        valid_reg[STAGES-2] && m_tvalid, "stage five lost a request during a stall")

endmodule

// File: test/date_gap_checker.sv
// Checker for the date difference block: predicts each result and compares it field by field.
`timescale 1ns / 1ps

module date_gap_checker #(
    parameter int YEAR_W = cdd_pkg::YEAR_BITS_DEF,
    localparam int DATE_W = cdd_pkg::DAY_W + cdd_pkg::MONTH_W + YEAR_W,
    localparam int S_TDATA_W = ((2 * DATE_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cdd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [YEAR_W-1:0]                 cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [S_TDATA_W-1:0]              s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [cdd_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [cdd_pkg::M_TUSER_W-1:0]     m_tuser,
    output int                                mismatch_count,
    output int                                open_count,
    output int                                checked_count
);

    localparam int COUNT_W = cdd_pkg::COUNT_W;
    localparam int DAY_W   = cdd_pkg::DAY_W;
    localparam int MONTH_W = cdd_pkg::MONTH_W;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               first_ok;
        logic               second_ok;
    } date_gap_t;

    // Expected results in request order, and the year window as last written.
    date_gap_t        pending_gaps[$];
    logic [YEAR_W-1:0] lo_year;
    logic [YEAR_W-1:0] hi_year;
    int               mismatch_total = 0;
    int               open_total     = 0;
    int               checked_total  = 0;

    assign mismatch_count = mismatch_total;
    assign open_count     = open_total;
    assign checked_count  = checked_total;

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    // Leap years from year zero up to, but not including, year y.
    function automatic int unsigned leap_days_before(input int unsigned y);
        int unsigned p;
        if (y == 0) begin
            return 0;
        end
        p = y - 1;
        return p / 4 - p / 100 + p / 400 + 1;
    endfunction

    // Zero for a month outside 1 to 12, which makes every day invalid.
    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int unsigned first_day_of_month(input int unsigned m);
        case (m)
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    function automatic bit date_in_calendar(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
        return (y >= 32'(lo_year)) && (y <= 32'(hi_year)) && (d >= 1)
            && (d <= month_days(m, y));
    endfunction

    // Days since 1 January of year zero; only meaningful for a valid date.
    function automatic int unsigned day_serial(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned doy;
        doy = first_day_of_month(m) + d - 1;
        if (m > 2 && is_leap_year(y)) begin
            doy = doy + 1;
        end
        return 365 * y + leap_days_before(y) + doy;
    endfunction

    function automatic date_gap_t predict_gap(input logic [S_TDATA_W-1:0] req);
        date_gap_t   res;
        int unsigned da, ma, ya, db, mb, yb;
        int unsigned na, nb;
        da = 32'(req[0 +: DAY_W]);
        ma = 32'(req[DAY_W +: MONTH_W]);
        ya = 32'(req[DAY_W + MONTH_W +: YEAR_W]);
        db = 32'(req[DATE_W +: DAY_W]);
        mb = 32'(req[DATE_W + DAY_W +: MONTH_W]);
        yb = 32'(req[DATE_W + DAY_W + MONTH_W +: YEAR_W]);
        res.first_ok  = date_in_calendar(da, ma, ya);
        res.second_ok = date_in_calendar(db, mb, yb);
        res.day_count = '0;
        if (res.first_ok && res.second_ok) begin
            na = day_serial(da, ma, ya);
            nb = day_serial(db, mb, yb);
            res.day_count = COUNT_W'((na > nb) ? (na - nb) : (nb - na));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_total++;
        if (mismatch_total <= 30) begin
            $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Track window writes, queue a prediction per request, check each result.
    always @(posedge aclk) begin
        date_gap_t want;
        if (!aresetn) begin
            pending_gaps.delete();
            open_total = 0;
            lo_year    = YEAR_W'(cdd_pkg::LOW_YEAR_RESET);
            hi_year    = YEAR_W'(cdd_pkg::HIGH_YEAR_RESET);
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == cdd_pkg::CFG_LOW_YEAR) begin
                    lo_year = cfg_wdata;
                end else if (cfg_index == cdd_pkg::CFG_HIGH_YEAR) begin
                    hi_year = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                pending_gaps.push_back(predict_gap(s_tdata));
                open_total++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_gaps.size() == 0) begin
                    report_mismatch("unrequested result", 32'(m_tdata[COUNT_W-1:0]), 0);
                end else begin
                    want = pending_gaps.pop_front();
                    open_total--;
                    checked_total++;
                    if (m_tdata[COUNT_W-1:0] !== want.day_count) begin
                        report_mismatch("day_count", 32'(m_tdata[COUNT_W-1:0]),
                                        32'(want.day_count));
                    end
                    if (m_tuser[0] !== want.first_ok) begin
                        report_mismatch("first_valid", 32'(m_tuser[0]), 32'(want.first_ok));
                    end
                    if (m_tuser[1] !== want.second_ok) begin
                        report_mismatch("second_valid", 32'(m_tuser[1]),
                                        32'(want.second_ok));
                    end
                end
            end
        end
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the date difference block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int YEAR_W      = cdd_pkg::YEAR_BITS_DEF;
    localparam int YEAR_MAX    = (1 << YEAR_W) - 1;
    localparam int DATE_W      = cdd_pkg::DAY_W + cdd_pkg::MONTH_W + YEAR_W;
    localparam int S_TDATA_W   = ((2 * DATE_W + 7) / 8) * 8;
    localparam int S_PAD_W     = S_TDATA_W - 2 * DATE_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 120;

    typedef struct packed {
        logic [cdd_pkg::DAY_W-1:0]   day;
        logic [cdd_pkg::MONTH_W-1:0] month;
        logic [YEAR_W-1:0]           year;
    } cal_date_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [cdd_pkg::CFG_INDEX_W-1:0] cfg_index = cdd_pkg::CFG_LOW_YEAR;
    logic [YEAR_W-1:0]               cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [S_TDATA_W-1:0]            s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [cdd_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [cdd_pkg::M_TUSER_W-1:0]   m_tuser;

    int mismatch_count;
    int open_count;
    int checked_count;
    int requests_sent = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    bit long_hold_req = 1'b0;

    calendar_date_difference_top #(
        .YEAR_BITS(YEAR_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    date_gap_checker #(
        .YEAR_W(YEAR_W)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatch_count(mismatch_count),
        .open_count    (open_count),
        .checked_count (checked_count)
    );

    always #2 aclk = ~aclk;

    // Run guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("calendar_date_difference_top test failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (long_hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one date pair and wait until it is taken.
    task automatic send_pair(input int da, input int ma, input int ya,
                             input int db, input int mb, input int yb);
        logic [cdd_pkg::DAY_W-1:0]   day_a, day_b;
        logic [cdd_pkg::MONTH_W-1:0] month_a, month_b;
        logic [YEAR_W-1:0]           year_a, year_b;
        day_a   = cdd_pkg::DAY_W'(da);
        month_a = cdd_pkg::MONTH_W'(ma);
        year_a  = YEAR_W'(ya);
        day_b   = cdd_pkg::DAY_W'(db);
        month_b = cdd_pkg::MONTH_W'(mb);
        year_b  = YEAR_W'(yb);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD_W{1'b0}}, year_b, month_b, day_b, year_a, month_a, day_a};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        requests_sent++;
    endtask

    // Stop offering and wait until every request has its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (open_count != 0);
        @(posedge aclk);
    endtask

    // Load both window registers; only called with the pipeline empty.
    task automatic set_window(input int lo, input int hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= cdd_pkg::CFG_LOW_YEAR;
        cfg_wdata <= YEAR_W'(lo);
        @(posedge aclk);
        cfg_index <= cdd_pkg::CFG_HIGH_YEAR;
        cfg_wdata <= YEAR_W'(hi);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly valid dates inside the window, with a share of broken ones.
    function automatic cal_date_t random_date(input int lo, input int hi);
        cal_date_t d;
        int        pick;
        pick    = $urandom_range(99);
        d.month = cdd_pkg::MONTH_W'($urandom_range(12, 1));
        d.day   = cdd_pkg::DAY_W'((pick % 5 == 0) ? $urandom_range(31, 29)
                                                  : $urandom_range(28, 1));
        d.year  = YEAR_W'((lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(YEAR_MAX, 0));
        if (pick >= 92) begin
            d.day   = cdd_pkg::DAY_W'($urandom_range(31, 0));
            d.month = cdd_pkg::MONTH_W'($urandom_range(15, 0));
            d.year  = YEAR_W'($urandom_range(YEAR_MAX, 0));
        end else if (pick >= 86) begin
            d.month = cdd_pkg::MONTH_W'($urandom_range(1, 0) ? 0 : $urandom_range(15, 13));
        end else if (pick >= 80) begin
            d.year = YEAR_W'($urandom_range(1, 0) ? lo - 1 : hi + 1);
        end else if (pick >= 77) begin
            d.day = '0;
        end
        return d;
    endfunction

    task automatic run_phase(input int n, input int lo, input int hi,
                             input int tx_pct, input int rx_pct);
        cal_date_t a;
        cal_date_t b;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        set_window(lo, hi);
        repeat (n) begin
            a = random_date(lo, hi);
            b = random_date(lo, hi);
            send_pair(int'(a.day), int'(a.month), int'(a.year),
                      int'(b.day), int'(b.month), int'(b.year));
        end
        drain();
    endtask

    initial begin
        int lo;
        int hi;
        tx_idle_pct = 26;
        rx_idle_pct <= 46;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window 1001 to 2018: leap rules, window edges, bad days and months.
        send_pair(1, 1, 2000, 1, 1, 2000);
        send_pair(29, 2, 2000, 1, 3, 2000);
        send_pair(29, 2, 1900, 1, 1, 1900);
        send_pair(29, 2, 2016, 28, 2, 2017);
        send_pair(29, 2, 2017, 1, 3, 2017);
        send_pair(31, 12, 2018, 1, 1, 1001);
        send_pair(1, 1, 1000, 1, 1, 2019);
        send_pair(0, 5, 1500, 31, 1, 1999);
        send_pair(31, 4, 1999, 30, 4, 1999);
        send_pair(31, 0, 1500, 1, 13, 1500);
        send_pair(31, 15, YEAR_MAX, 15, 14, 1800);
        send_pair(1, 3, 1600, 29, 2, 1600);
        drain();

        // Full year range: year zero, the largest span and all-ones fields.
        set_window(0, YEAR_MAX);
        send_pair(1, 1, 0, 31, 12, YEAR_MAX);
        send_pair(31, 12, YEAR_MAX, 1, 1, 0);
        send_pair(29, 2, 0, 1, 3, 0);
        send_pair(29, 2, 4000, 29, 2, 4004);
        send_pair(29, 2, YEAR_MAX, 28, 2, YEAR_MAX);
        send_pair(1, 3, 1, 28, 2, 1);
        send_pair(31, 15, YEAR_MAX, 31, 15, YEAR_MAX);
        send_pair(16, 8, 2048, 15, 7, 2047);
        drain();

        // Random part over several windows and idling patterns.
        run_phase(150, cdd_pkg::LOW_YEAR_RESET, cdd_pkg::HIGH_YEAR_RESET, 26, 46);
        run_phase(250, 0, YEAR_MAX, 26, 46);
        run_phase(200, 1582, 2400, 46, 26);
        run_phase(50, 3000, 1000, 46, 26);
        run_phase(60, 2000, 2000, 46, 26);
        run_phase(50, 0, 0, 0, 0);
        run_phase(50, YEAR_MAX, YEAR_MAX, 0, 0);

        // Random window while the receiver stalls long enough to fill the pipeline.
        lo = $urandom_range(YEAR_MAX, 0);
        hi = $urandom_range(YEAR_MAX, lo);
        long_hold_req <= 1'b1;
        run_phase(240, lo, hi, 0, 0);

        // Give any stray result a chance to show up.
        repeat (2 * cdd_pkg::PIPE_STAGES) @(posedge aclk);

        $display("Sent %0d date pairs and checked %0d results over ten window settings,",
                 requests_sent, checked_count);
        $display("including empty and single-year windows and a long receiver stall.");
        if (mismatch_count == 0 && open_count == 0) begin
            $display("calendar_date_difference_top test passed");
        end else begin
            $display("calendar_date_difference_top test failed");
        end
        $finish;
    end

endmodule
